// ----- hdl/serial_frame_receiver_top_assert.svh -----
// Assertion macros for the serial frame receiver checker.
// Included by the checker file only; needs nothing else.
`ifndef SERIAL_FRAME_RECEIVER_TOP_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("serial frame receiver: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("serial frame receiver: next-cycle check failed");

`endif

// ----- hdl/sfr_pkg.sv -----
// Shared constants, codes and control types of the serial frame receiver.
// No dependencies.
package sfr_pkg;

   localparam logic [7:0] START_BYTE = 8'hAA;
   localparam logic [7:0] END_BYTE   = 8'h55;

   // Width of the frame byte counter and of the payload index.
   localparam int COUNT_W = 6;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_SUM = 2'd1,
      STATUS_BAD_END = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_TAKE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_SEND  = 3'b100
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic rd_en;
      logic idx_inc;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic at_end;
      logic frame_bad;
      logic last_rsp;
   } stat_type;

endpackage

// ----- hdl/sfr_if.sv -----
// Valid/ready channel interfaces for received bytes and frame results.
// Uses sfr_pkg for the byte index width.
interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    frame_status;
   logic [7:0]                    frame_type;
   logic [7:0]                    declared_length;
   logic [sfr_pkg::COUNT_W-1:0]   byte_index;
   logic [7:0]                    payload_byte;
   logic                          last_of_frame;

   modport source (output valid, output frame_status, output frame_type,
                   output declared_length, output byte_index, output payload_byte,
                   output last_of_frame, input ready);
   modport sink (input valid, input frame_status, input frame_type,
                 input declared_length, input byte_index, input payload_byte,
                 input last_of_frame, output ready);
endinterface

// ----- hdl/sfr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/sfr_datapath.sv -----
// Datapath of the serial frame receiver: byte counter, checksum, held header
// fields, payload RAM and result fields. Uses sfr_pkg and sfr_ram.
module sfr_datapath #(
   parameter int PAYLOAD_BYTES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sfr_pkg::cmd_type            cmd,
   input  logic [7:0]                  rx_byte,
   output sfr_pkg::stat_type           stat,
   output logic [1:0]                  frame_status,
   output logic [7:0]                  frame_type,
   output logic [7:0]                  declared_length,
   output logic [sfr_pkg::COUNT_W-1:0] byte_index,
   output logic [7:0]                  payload_byte,
   output logic                        last_of_frame
);

   localparam int CW       = sfr_pkg::COUNT_W;
   localparam int AW       = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int SUM_SLOT = 3 + PAYLOAD_BYTES;
   localparam int END_SLOT = 4 + PAYLOAD_BYTES;

   localparam logic [CW-1:0] CNT_SUM  = CW'(SUM_SLOT);
   localparam logic [CW-1:0] CNT_END  = CW'(END_SLOT);
   localparam logic [CW-1:0] CNT_TYPE = CW'(1);
   localparam logic [CW-1:0] CNT_LEN  = CW'(2);
   localparam logic [CW-1:0] CNT_PAY  = CW'(3);
   localparam logic [CW-1:0] IDX_LAST = CW'(PAYLOAD_BYTES - 1);

   logic [CW-1:0]        count_ff, count_in;
   logic [7:0]           sum_ff, sum_in;
   logic [7:0]           type_ff, type_in;
   logic [7:0]           len_ff, len_in;
   logic [7:0]           chk_ff, chk_in;
   logic [CW-1:0]        idx_ff, idx_in;
   sfr_pkg::status_type  status_ff, status_in;

   logic                 wr_en;
   logic [CW-1:0]        slot_full;
   logic [7:0]           rd_data;
   logic                 bad_end;
   logic                 bad_sum;

   assign bad_end   = (rx_byte != sfr_pkg::END_BYTE);
   assign bad_sum   = (sum_ff != chk_ff);
   assign slot_full = count_ff - CNT_PAY;
   assign wr_en     = cmd.take && (count_ff >= CNT_PAY) && (count_ff < CNT_SUM);

   always_comb begin
      count_in  = count_ff;
      sum_in    = sum_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      chk_in    = chk_ff;
      status_in = status_ff;
      if (cmd.take) begin
         if (count_ff == '0) begin
            if (rx_byte == sfr_pkg::START_BYTE) begin
               sum_in   = rx_byte;
               count_in = CNT_TYPE;
            end
         end else if (count_ff == CNT_END) begin
            count_in = '0;
            sum_in   = '0;
            if (bad_end) begin
               status_in = sfr_pkg::STATUS_BAD_END;
            end else if (bad_sum) begin
               status_in = sfr_pkg::STATUS_BAD_SUM;
            end else begin
               status_in = sfr_pkg::STATUS_OK;
            end
         end else if (count_ff == CNT_SUM) begin
            chk_in   = rx_byte;
            count_in = count_ff + CW'(1);
         end else begin
            if (count_ff == CNT_TYPE) begin
               type_in = rx_byte;
            end else if (count_ff == CNT_LEN) begin
               len_in = rx_byte;
            end
            sum_in   = sum_ff + rx_byte;
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.take) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sum_ff    <= '0;
         type_ff   <= '0;
         len_ff    <= '0;
         chk_ff    <= '0;
         idx_ff    <= '0;
         status_ff <= sfr_pkg::STATUS_OK;
      end else begin
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         type_ff   <= type_in;
         len_ff    <= len_in;
         chk_ff    <= chk_in;
         idx_ff    <= idx_in;
         status_ff <= status_in;
      end
   end

   sfr_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_BYTES)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_full[AW-1:0]),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign stat.at_end    = (count_ff == CNT_END);
   assign stat.frame_bad = bad_end || bad_sum;
   assign stat.last_rsp  = last_of_frame;

   assign frame_status    = status_ff;
   assign frame_type      = type_ff;
   assign declared_length = len_ff;
   assign byte_index      = idx_ff;
   assign payload_byte    = (status_ff == sfr_pkg::STATUS_OK) ? rd_data : 8'd0;
   assign last_of_frame   = (status_ff != sfr_pkg::STATUS_OK) || (idx_ff == IDX_LAST);

endmodule

// ----- hdl/sfr_ctrl.sv -----
// Controller of the serial frame receiver: takes bytes, then fetches and
// presents the results of a finished frame. Uses sfr_pkg.
module sfr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  sfr_pkg::stat_type stat,
   output sfr_pkg::cmd_type  cmd
);

   sfr_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.take    = 1'b0;
      cmd.rd_en   = 1'b0;
      cmd.idx_inc = 1'b0;
      unique case (state_ff)
         sfr_pkg::ST_TAKE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
            if (req_valid && stat.at_end) begin
               state_in = stat.frame_bad ? sfr_pkg::ST_SEND : sfr_pkg::ST_FETCH;
            end
         end
         sfr_pkg::ST_FETCH: begin
            cmd.rd_en = 1'b1;
            state_in  = sfr_pkg::ST_SEND;
         end
         sfr_pkg::ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (stat.last_rsp) begin
                  state_in = sfr_pkg::ST_TAKE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = sfr_pkg::ST_FETCH;
               end
            end
         end
         default: begin
            state_in = sfr_pkg::ST_TAKE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfr_pkg::ST_TAKE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/serial_frame_receiver_top.sv -----
// Serial frame receiver. Each input item is one received byte; the block hunts
// for the start byte 0xAA and then collects a fixed frame of type, length,
// PAYLOAD_BYTES payload bytes, an 8-bit additive checksum and the end byte 0x55.
// While a frame is being received one byte is accepted every cycle. When the
// end byte arrives, input is held off until the frame's results are all taken:
// a bad end byte or a checksum mismatch gives a single error item the next
// cycle, and a good frame gives PAYLOAD_BYTES items, each made by a read of
// the payload RAM and then its presentation, and each held as long as the
// output stalls. The items come one at a time because the payload RAM has a
// single registered read port. The length byte is passed through with each item
// but is never checked.

module serial_frame_receiver_top #(
   parameter int PAYLOAD_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   sfr_req_if.sink     req_chan,
   sfr_rsp_if.source   rsp_chan
);

   // Command and status between the controller and the datapath.
   sfr_pkg::cmd_type  cmd;
   sfr_pkg::stat_type stat;

   // The controller owns both handshakes; it only accepts a byte when no
   // result is pending, so the datapath's held fields stay stable for output.
   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath keeps the frame state and the payload, and forms every
   // field of the result item directly from its registers.
   sfr_datapath #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .rx_byte         (req_chan.rx_byte),
      .stat            (stat),
      .frame_status    (rsp_chan.frame_status),
      .frame_type      (rsp_chan.frame_type),
      .declared_length (rsp_chan.declared_length),
      .byte_index      (rsp_chan.byte_index),
      .payload_byte    (rsp_chan.payload_byte),
      .last_of_frame   (rsp_chan.last_of_frame)
   );

endmodule

// ----- hdl/sfr_checker.sv -----
// Port-level checks for the serial frame receiver, bound to the top level.
// Uses sfr_pkg and the assertion macros header.
`include "serial_frame_receiver_top_assert.svh"

module sfr_checker #(
   parameter int PAYLOAD_BYTES = 8
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_status,
   input logic [sfr_pkg::COUNT_W-1:0] rsp_index,
   input logic [7:0]                  rsp_payload,
   input logic                        rsp_last
);

   localparam int CW = sfr_pkg::COUNT_W;
   localparam int FW = 2 + CW + 8 + 1;
   localparam logic [CW-1:0] IDX_MAX = CW'(PAYLOAD_BYTES - 1);

   logic          rsp_stall;
   logic [FW-1:0] rsp_fields;
   logic          rsp_err;
   logic          err_clean;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_fields = {rsp_status, rsp_index, rsp_payload, rsp_last};
   assign rsp_err    = rsp_valid && (rsp_status != sfr_pkg::STATUS_OK);
   assign err_clean  = rsp_last && (rsp_index == '0) && (rsp_payload == 8'd0);

   // A stalled result item keeps its fields.
   `SFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_fields))

   // No byte is taken while a result waits.
   `SFR_ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid, !req_ready)

   // Error items are single, with a zero index and payload.
   `SFR_ASSERT_NOW(a_err_shape, clock, reset, rsp_err, err_clean)

   // The payload index never passes the last payload byte, and the frame
   // stays busy after a result that is not its last.
   `SFR_ASSERT_NOW(a_index_range, clock, reset, rsp_valid, rsp_index <= IDX_MAX)
   `SFR_ASSERT_NEXT(a_burst_busy, clock, reset, rsp_valid && rsp_ready && !rsp_last, !req_ready)

endmodule

bind serial_frame_receiver_top sfr_checker #(
   .PAYLOAD_BYTES (PAYLOAD_BYTES)
) u_sfr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_status  (rsp_chan.frame_status),
   .rsp_index   (rsp_chan.byte_index),
   .rsp_payload (rsp_chan.payload_byte),
   .rsp_last    (rsp_chan.last_of_frame)
);

// ----- tb/tb.sv -----
// Self-checking testbench for serial_frame_receiver_top: frames, noise and broken
// frames go in, and every result item is checked against an in-bench frame parser.
// Depends on sfr_pkg, on the sfr_req_if and sfr_rsp_if interfaces, and on the top.
module tb;

   localparam int PAYLOAD_BYTES = 8;
   localparam int HALF_PERIOD = 10;
   // Position of the checksum byte and of the end byte within a frame.
   localparam int SUM_POS = 3 + PAYLOAD_BYTES;
   localparam int END_POS = 4 + PAYLOAD_BYTES;
   // Margin that wait_for_results leaves for the block to settle.
   localparam int SETTLE_CYCLES = 2 * PAYLOAD_BYTES + 8;

   // How a generated frame is to be spoiled, if at all.
   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_SUM,
      FRAME_BAD_END,
      FRAME_BAD_BOTH
   } frame_kind_type;

   // One expected result item, at the widths of the result channel.
   typedef struct {
      sfr_pkg::status_type          status;
      logic [7:0]                   ftype;
      logic [7:0]                   flen;
      logic [sfr_pkg::COUNT_W-1:0]  index;
      logic [7:0]                   data;
      logic                         last;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sfr_req_if req_if ();
   sfr_rsp_if rsp_if ();

   serial_frame_receiver_top #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Frame parser that predicts the block. Its state mirrors the block's:
   // the position within the frame (zero while hunting for a start byte),
   // the wrapping sum, the held header and checksum bytes, and the payload.
   // ------------------------------------------------------------------------
   int         rx_pos = 0;
   logic [7:0] frame_sum = 8'h00;
   logic [7:0] held_type = 8'h00;
   logic [7:0] held_length = 8'h00;
   logic [7:0] held_checksum = 8'h00;
   logic [7:0] stored_payload [PAYLOAD_BYTES];

   frame_result_type pending_results[$];
   int error_count = 0;

   task automatic push_result(input sfr_pkg::status_type status, input int index,
                              input logic [7:0] data, input logic last);
      frame_result_type r;
      r.status = status;
      r.ftype  = held_type;
      r.flen   = held_length;
      r.index  = index[sfr_pkg::COUNT_W-1:0];
      r.data   = data;
      r.last   = last;
      pending_results.push_back(r);
   endtask

   // Advances the parser by one accepted byte and queues what that byte causes.
   task automatic parse_byte(input logic [7:0] b);
      int i;
      if (rx_pos == 0) begin
         // While hunting, everything but the start byte is dropped.
         if (b == sfr_pkg::START_BYTE) begin
            frame_sum = b;
            rx_pos = 1;
         end
      end else if (rx_pos == SUM_POS) begin
         // The checksum byte itself is not part of the sum.
         held_checksum = b;
         rx_pos = rx_pos + 1;
      end else if (rx_pos == END_POS) begin
         // A bad end byte wins over a bad checksum.
         if (b != sfr_pkg::END_BYTE) begin
            push_result(sfr_pkg::STATUS_BAD_END, 0, 8'h00, 1'b1);
         end else if (frame_sum != held_checksum) begin
            push_result(sfr_pkg::STATUS_BAD_SUM, 0, 8'h00, 1'b1);
         end else begin
            for (i = 0; i < PAYLOAD_BYTES; i++)
               push_result(sfr_pkg::STATUS_OK, i, stored_payload[i],
                           i == PAYLOAD_BYTES - 1);
         end
         rx_pos = 0;
         frame_sum = 8'h00;
      end else begin
         // Type, length and payload; a start byte in here is just data.
         if (rx_pos == 1)
            held_type = b;
         else if (rx_pos == 2)
            held_length = b;
         else
            stored_payload[rx_pos - 3] = b;
         frame_sum = frame_sum + b;
         rx_pos = rx_pos + 1;
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor and checker. Both channels are sampled at the rising edge, where
   // the values driven at the falling edge are stable. The input side is
   // parsed first so that an expectation always exists before its result.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      frame_result_type exp_r;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            parse_byte(req_if.rx_byte);
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result item: status %0d type %02h index %0d",
                        $time, rsp_if.frame_status, rsp_if.frame_type,
                        rsp_if.byte_index);
               error_count++;
            end else begin
               exp_r = pending_results.pop_front();
               if (rsp_if.frame_status !== exp_r.status) begin
                  $display("%0t: frame_status expected %0d, got %0d",
                           $time, exp_r.status, rsp_if.frame_status);
                  error_count++;
               end
               if (rsp_if.frame_type !== exp_r.ftype) begin
                  $display("%0t: frame_type expected %02h, got %02h",
                           $time, exp_r.ftype, rsp_if.frame_type);
                  error_count++;
               end
               if (rsp_if.declared_length !== exp_r.flen) begin
                  $display("%0t: declared_length expected %02h, got %02h",
                           $time, exp_r.flen, rsp_if.declared_length);
                  error_count++;
               end
               if (rsp_if.byte_index !== exp_r.index) begin
                  $display("%0t: byte_index expected %0d, got %0d",
                           $time, exp_r.index, rsp_if.byte_index);
                  error_count++;
               end
               if (rsp_if.payload_byte !== exp_r.data) begin
                  $display("%0t: payload_byte expected %02h, got %02h",
                           $time, exp_r.data, rsp_if.payload_byte);
                  error_count++;
               end
               if (rsp_if.last_of_frame !== exp_r.last) begin
                  $display("%0t: last_of_frame expected %0b, got %0b",
                           $time, exp_r.last, rsp_if.last_of_frame);
                  error_count++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver side. Ready follows a random 16-bit pattern that rotates every
   // cycle and is redrawn as each window ends. The top bit is always clear, so
   // no stall lasts a full rotation. About one window in four has no stalls.
   // ------------------------------------------------------------------------
   logic [15:0] stall_bits = 16'h0000;
   logic        receiver_stalls = 1'b0;
   int          stall_window = 0;

   always @(negedge clock) begin
      if (stall_window == 0) begin
         stall_bits <= 16'($urandom) & 16'h7FFF;
         receiver_stalls <= ($urandom_range(0, 3) != 0);
         stall_window <= 32;
         rsp_if.ready <= 1'b1;
      end else begin
         stall_bits <= {stall_bits[0], stall_bits[15:1]};
         stall_window <= stall_window - 1;
         rsp_if.ready <= !(receiver_stalls && stall_bits[0]);
      end
   end

   // ------------------------------------------------------------------------
   // Sender side. Items go out in bursts of random length with random gaps in
   // between. When sender_idles is low, valid stays high from item to item.
   // ------------------------------------------------------------------------
   logic sender_idles = 1'b1;
   int   burst_left = 0;

   task automatic send_byte(input logic [7:0] b);
      int gap;
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      if (sender_idles && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_if.valid <= 1'b0;
         req_if.rx_byte <= 8'($urandom);
         repeat (gap - 1) @(negedge clock);
      end else if (burst_left > 0) begin
         burst_left--;
      end
   endtask

   // Stops sending and waits until every expected result item has come, then
   // lets the block settle.
   task automatic wait_for_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Builds a frame of the given kind and sends its first nbytes bytes. A short
   // count leaves a broken frame behind for the next bytes to complete.
   task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flen,
                             input logic [7:0] payload [PAYLOAD_BYTES],
                             input frame_kind_type kind, input int nbytes);
      logic [7:0] frame_bytes[$];
      logic [7:0] sum;
      logic [7:0] end_byte;
      int i;
      frame_bytes = {sfr_pkg::START_BYTE, ftype, flen};
      for (i = 0; i < PAYLOAD_BYTES; i++) frame_bytes.push_back(payload[i]);
      sum = 8'h00;
      foreach (frame_bytes[j]) sum = sum + frame_bytes[j];
      if (kind == FRAME_BAD_SUM || kind == FRAME_BAD_BOTH)
         sum = sum ^ 8'($urandom_range(1, 255));
      end_byte = sfr_pkg::END_BYTE;
      if (kind == FRAME_BAD_END || kind == FRAME_BAD_BOTH) begin
         do end_byte = 8'($urandom); while (end_byte == sfr_pkg::END_BYTE);
      end
      frame_bytes.push_back(sum);
      frame_bytes.push_back(end_byte);
      for (i = 0; i < nbytes && i < frame_bytes.size(); i++)
         send_byte(frame_bytes[i]);
   endtask

   task automatic random_payload(output logic [7:0] payload [PAYLOAD_BYTES]);
      int i;
      for (i = 0; i < PAYLOAD_BYTES; i++) begin
         case ($urandom_range(0, 7))
            0: payload[i] = 8'h00;
            1: payload[i] = 8'hFF;
            2: payload[i] = sfr_pkg::START_BYTE;
            default: payload[i] = 8'($urandom);
         endcase
      end
   endtask

   // ------------------------------------------------------------------------
   // Directed tests.
   // ------------------------------------------------------------------------

   // Bytes before any start byte are dropped and give no result.
   task automatic test_hunt_noise();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(sfr_pkg::END_BYTE);
      send_byte(8'h7E);
   endtask

   // A good frame with extreme header bytes. The payload holds both extremes
   // and a start byte, which must be taken as plain data inside a frame.
   task automatic test_good_frame();
      logic [7:0] payload [PAYLOAD_BYTES];
      payload = '{8'h00, 8'hFF, sfr_pkg::START_BYTE, sfr_pkg::END_BYTE,
                  8'h01, 8'h80, 8'h7F, 8'hFE};
      send_frame(8'hFF, 8'h00, payload, FRAME_GOOD, END_POS + 1);
   endtask

   // A checksum mismatch with the end byte intact gives one checksum error.
   task automatic test_bad_checksum();
      logic [7:0] payload [PAYLOAD_BYTES];
      random_payload(payload);
      send_frame(8'h00, 8'hFF, payload, FRAME_BAD_SUM, END_POS + 1);
   endtask

   // A bad end byte on top of a bad checksum gives the end byte error only.
   task automatic test_bad_end_and_checksum();
      logic [7:0] payload [PAYLOAD_BYTES];
      random_payload(payload);
      send_frame(8'h5A, 8'h08, payload, FRAME_BAD_BOTH, END_POS + 1);
   endtask

   // ------------------------------------------------------------------------
   // Random traffic: mostly whole frames with random content, plus frames with
   // each kind of error, frames cut short and stray noise bytes. Noise bytes
   // do not count toward the item budget.
   // ------------------------------------------------------------------------
   task automatic test_random_traffic(input int item_budget);
      logic [7:0] payload [PAYLOAD_BYTES];
      frame_kind_type kind;
      int sent;
      int pick;
      int n;
      int i;
      bit paused;
      sent = 0;
      paused = 0;
      while (sent < item_budget) begin
         sender_idles = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 90) begin
            if (pick < 60)      kind = FRAME_GOOD;
            else if (pick < 70) kind = FRAME_BAD_SUM;
            else if (pick < 78) kind = FRAME_BAD_END;
            else if (pick < 82) kind = FRAME_BAD_BOTH;
            else                kind = frame_kind_type'($urandom_range(0, 3));
            // The last band sends a frame that stops part way through.
            n = (pick < 82) ? END_POS + 1 : $urandom_range(1, END_POS);
            random_payload(payload);
            send_frame(8'($urandom), 8'($urandom), payload, kind, n);
            sent += n;
         end else begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) send_byte(8'($urandom));
         end
         // Once, about half way, the sender holds off until all results are in.
         if (!paused && sent >= item_budget / 2) begin
            paused = 1;
            wait_for_results();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence of the run.
   // ------------------------------------------------------------------------
   initial begin
      req_if.valid = 1'b0;
      req_if.rx_byte = 8'h00;
      rsp_if.ready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_hunt_noise();
      test_good_frame();
      test_bad_checksum();
      test_bad_end_and_checksum();
      wait_for_results();

      test_random_traffic(130);
      wait_for_results();

      if (error_count == 0 && pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Guard against a hang: far beyond the slowest correct run.
   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

endmodule
